### rtl/crt_pkg.sv
// shared types and codes for the chunk reassembly table
package crt_pkg;

  localparam logic [1:0] CMD_CHUNK   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_LARGE    = 3'd5;

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [6:0] PCT_CAP  = 7'd99;
  localparam logic [6:0] PCT_MUL  = 7'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_DIV,
    S_OUT
  } crt_state_t;

endpackage

### rtl/chunk_reassembly_table_core.sv
// chunk reassembly table: slot search, payload memory and percent divider
//
// one beat in on the in_ channel gives exactly one beat out on the out_ channel.
// command 0 stores one chunk byte (opening a slot for a new id), command 1 reads a
// stored byte, command 2 frees a slot and command 3 reports the slot's percent.
// an item goes through capture, slot search, execute (slot metadata update and
// one payload memory access), a seven-step restoring divider for the percent and
// a load into the output register; a new beat is taken only once the last
// item has been loaded into the output register. the divider makes one
// quotient bit per cycle.
// in_stall is high while an item is in flight; a result waiting under out_stall
// does not hold the input side, but the next result waits in the block until
// the output register is free.
// reset clears slot valid bits, the dropping flag, the state and out_valid;
// the payload memory is not cleared and needs no sweep.
module chunk_reassembly_table_core
  import crt_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int MAX_CHUNKS = 64,
  parameter int SLOT_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_message_id,
  input  logic [6:0]  in_chunk_total,
  input  logic [12:0] in_message_length,
  input  logic [15:0] in_chunk_index,
  input  logic [11:0] in_byte_offset,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_first,
  input  logic        in_chunk_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot_index,
  output logic [6:0]  out_percent_done,
  output logic        out_complete,
  output logic [7:0]  out_read_data
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int DEPTH = SLOTS * SLOT_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crt_state_t state_r, state_nxt;

  logic [1:0]  cmd_r;
  logic [15:0] id_r;
  logic [6:0]  total_r;
  logic [12:0] len_r;
  logic [15:0] idx_r;
  logic [11:0] off_r;
  logic [7:0]  data_r;
  logic        first_r;
  logic        last_r;

  logic                  slot_valid_r [SLOTS];
  logic [15:0]           slot_id_r [SLOTS];
  logic [6:0]            slot_total_r [SLOTS];
  logic [6:0]            slot_pres_r [SLOTS];
  logic [12:0]           slot_len_r [SLOTS];
  logic [MAX_CHUNKS-1:0] seen_r [SLOTS];
  logic                  dropping_r;

  logic [7:0] payload_mem [DEPTH];
  logic [7:0] rd_q;

  logic          hit_r, free_ok_r;
  logic [SW-1:0] hit_slot_r, free_slot_r;
  logic          hit_c, free_ok_c;
  logic [SW-1:0] hit_slot_c, free_slot_c;

  logic [2:0]    res_status_r;
  logic [SW-1:0] res_slot_r;
  logic          res_pct_r;
  logic          res_rd_r;
  logic          res_done_r;
  logic [13:0]   num_r;
  logic [6:0]    div_t_r;
  logic [6:0]    quo_r;
  logic [2:0]    cnt_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [2:0]    out_slot_r;
  logic [6:0]    out_pct_r;
  logic          out_done_r;
  logic [7:0]    out_rd_r;

  // execute stage signals
  logic [SW-1:0]         s_e;
  logic                  use_slot_e, open_e;
  logic [6:0]            tot_e, pres_e, pres_new_e;
  logic [12:0]           len_e;
  logic [MAX_CHUNKS-1:0] seen_e, seen_new_e;
  logic                  drop_new_e, wr_e, rd_e, free_e;
  logic [2:0]            status_e;
  logic                  off_in_e;
  logic [AW-1:0]         addr_e;
  logic [13:0]           trial;
  logic [6:0]            pct_final;
  logic                  in_acc, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 3'd0) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    hit_c       = 1'b0;
    hit_slot_c  = '0;
    free_ok_c   = 1'b0;
    free_slot_c = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && slot_id_r[i] == id_r) begin
        hit_c      = 1'b1;
        hit_slot_c = SW'(i);
      end
      if (!slot_valid_r[i]) begin
        free_ok_c   = 1'b1;
        free_slot_c = SW'(i);
      end
    end
  end

  always_comb begin
    s_e        = hit_r ? hit_slot_r : free_slot_r;
    open_e     = 1'b0;
    use_slot_e = hit_r;
    status_e   = ST_OK;
    drop_new_e = dropping_r;
    wr_e       = 1'b0;
    rd_e       = 1'b0;
    free_e     = 1'b0;
    off_in_e   = 1'b0;
    tot_e      = slot_total_r[s_e];
    pres_e     = slot_pres_r[s_e];
    len_e      = slot_len_r[s_e];
    seen_e     = seen_r[s_e];
    if (cmd_r == CMD_CHUNK && !hit_r) begin
      if (32'(total_r) > MAX_CHUNKS || 32'(len_r) > SLOT_BYTES) begin
        status_e = ST_LARGE;
      end else if (!free_ok_r) begin
        status_e = ST_FULL;
      end else begin
        open_e     = 1'b1;
        use_slot_e = 1'b1;
        tot_e      = total_r;
        pres_e     = '0;
        len_e      = len_r;
        seen_e     = '0;
      end
    end
    seen_new_e = seen_e;
    pres_new_e = pres_e;
    off_in_e   = (off_r < len_e[11:0] || len_e[12]) && (32'(off_r) < SLOT_BYTES);
    if (cmd_r == CMD_CHUNK) begin
      if (use_slot_e) begin
        if (idx_r >= 16'(tot_e) || 32'(idx_r) >= MAX_CHUNKS) begin
          drop_new_e = !last_r;
          status_e   = ST_RANGE;
        end else if (first_r && seen_e[idx_r[CIW-1:0]]) begin
          drop_new_e = !last_r;
          status_e   = ST_DUP;
        end else begin
          if (first_r) begin
            seen_new_e[idx_r[CIW-1:0]] = 1'b1;
            drop_new_e = 1'b0;
          end
          if (drop_new_e) begin
            status_e = ST_DUP;
          end else begin
            if (off_in_e) wr_e = 1'b1;
            else status_e = ST_LARGE;
            if (last_r && pres_e < tot_e) pres_new_e = pres_e + 7'd1;
          end
          if (last_r) drop_new_e = 1'b0;
        end
      end
    end else if (!hit_r) begin
      status_e = ST_NOTFOUND;
    end else if (cmd_r == CMD_READ) begin
      if (off_in_e) rd_e = 1'b1;
      else status_e = ST_RANGE;
    end else if (cmd_r == CMD_RELEASE) begin
      free_e = 1'b1;
    end
    addr_e = AW'(s_e) * AW'(SLOT_BYTES) + AW'(off_r);
  end

  assign trial = 14'(div_t_r) << cnt_r;
  assign pct_final = !res_pct_r ? 7'd0 : res_done_r ? PCT_FULL :
                     (quo_r > PCT_CAP) ? PCT_CAP : quo_r;

  always_ff @(posedge clk) begin
    if (wr_e && state_r == S_EXEC) payload_mem[addr_e] <= data_r;
    if (rd_e && state_r == S_EXEC) rd_q <= payload_mem[addr_e];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dropping_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_valid_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        cmd_r   <= in_command;
        id_r    <= in_message_id;
        total_r <= in_chunk_total;
        len_r   <= in_message_length;
        idx_r   <= in_chunk_index;
        off_r   <= in_byte_offset;
        data_r  <= in_data_byte;
        first_r <= in_chunk_first;
        last_r  <= in_chunk_last;
      end
      if (state_r == S_LOOK) begin
        hit_r       <= hit_c;
        hit_slot_r  <= hit_slot_c;
        free_ok_r   <= free_ok_c;
        free_slot_r <= free_slot_c;
      end
      if (state_r == S_EXEC) begin
        dropping_r <= drop_new_e;
        if (open_e) begin
          slot_valid_r[s_e] <= 1'b1;
          slot_id_r[s_e]    <= id_r;
          slot_total_r[s_e] <= total_r;
          slot_len_r[s_e]   <= len_r;
        end
        if (use_slot_e) begin
          slot_pres_r[s_e] <= pres_new_e;
          seen_r[s_e]      <= seen_new_e;
        end
        if (free_e) slot_valid_r[s_e] <= 1'b0;
        res_status_r <= status_e;
        res_slot_r   <= use_slot_e ? s_e : '0;
        res_pct_r    <= use_slot_e && !free_e;
        res_rd_r     <= rd_e;
        res_done_r   <= pres_new_e >= tot_e;
        num_r        <= 14'(pres_new_e) * 14'(PCT_MUL);
        div_t_r      <= tot_e;
        quo_r        <= '0;
        cnt_r        <= 3'd6;
      end
      if (state_r == S_DIV) begin
        if (num_r >= trial && div_t_r != 7'd0) begin
          num_r        <= num_r - trial;
          quo_r[cnt_r] <= 1'b1;
        end
        if (cnt_r != 3'd0) cnt_r <= cnt_r - 3'd1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_slot_r   <= 3'(res_slot_r);
        out_pct_r    <= pct_final;
        out_done_r   <= res_pct_r && res_done_r;
        out_rd_r     <= res_rd_r ? rd_q : 8'd0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_slot_r;
  assign out_percent_done = out_pct_r;
  assign out_complete     = out_done_r;
  assign out_read_data    = out_rd_r;

endmodule

### dv/chunk_reassembly_table_core_test.sv
// self-checking testbench for the chunk reassembly table core
`timescale 1ns / 1ps
module chunk_reassembly_table_core_test;
  import crt_pkg::*;

  localparam int NSLOT = 8;
  localparam int NCHUNK = 64;
  localparam int NBYTES = 4096;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] message_id;
    logic [6:0]  chunk_total;
    logic [12:0] message_length;
    logic [15:0] chunk_index;
    logic [11:0] byte_offset;
    logic [7:0]  data_byte;
    logic        chunk_first;
    logic        chunk_last;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_index;
    logic [6:0] percent_done;
    logic       complete;
    logic [7:0] read_data;
  } resp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [15:0] in_message_id = '0;
  logic [6:0] in_chunk_total = '0;
  logic [12:0] in_message_length = '0;
  logic [15:0] in_chunk_index = '0;
  logic [11:0] in_byte_offset = '0;
  logic [7:0] in_data_byte = '0;
  logic in_chunk_first = 0;
  logic in_chunk_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [2:0] out_slot_index;
  logic [6:0] out_percent_done;
  logic out_complete;
  logic [7:0] out_read_data;

  chunk_reassembly_table_core dut (.*);

  always #10 clk = ~clk;

  // model copy of the table
  bit          tbl_valid [NSLOT];
  logic [15:0] tbl_id [NSLOT];
  logic [6:0]  tbl_total [NSLOT];
  logic [6:0]  tbl_present [NSLOT];
  logic [12:0] tbl_len [NSLOT];
  logic [63:0] tbl_seen [NSLOT];
  logic [7:0]  tbl_bytes [NSLOT*NBYTES];
  bit          tbl_written [NSLOT*NBYTES];
  bit          dropping;

  req_t  pending_beats [$];
  resp_t expected_resps [$];
  int    errors = 0;
  int    in_idle_pct = 0;
  int    out_stall_pct = 0;
  bit    stim_done = 0;
  int    cycles = 0;
  bit    in_acc_seen = 0;

  function automatic int find_slot(logic [15:0] id);
    for (int s = 0; s < NSLOT; s++)
      if (tbl_valid[s] && tbl_id[s] == id) return s;
    return -1;
  endfunction

  function automatic logic [6:0] slot_percent(int s);
    int q;
    if (tbl_present[s] >= tbl_total[s]) return PCT_FULL;
    q = (tbl_present[s] * 100) / tbl_total[s];
    return (q > 99) ? PCT_CAP : 7'(q);
  endfunction

  function automatic logic [2:0] store_chunk_byte(req_t r, int s);
    logic [2:0] st;
    st = ST_OK;
    if (r.chunk_index >= tbl_total[s] || r.chunk_index >= NCHUNK) begin
      dropping = !r.chunk_last;
      return ST_RANGE;
    end
    if (r.chunk_first) begin
      if (tbl_seen[s][r.chunk_index[5:0]]) begin
        dropping = !r.chunk_last;
        return ST_DUP;
      end
      tbl_seen[s][r.chunk_index[5:0]] = 1'b1;
      dropping = 0;
    end
    if (dropping) st = ST_DUP;
    else begin
      if (r.byte_offset < tbl_len[s]) begin
        tbl_bytes[s*NBYTES + r.byte_offset] = r.data_byte;
        tbl_written[s*NBYTES + r.byte_offset] = 1;
      end else st = ST_LARGE;
      if (r.chunk_last && tbl_present[s] < tbl_total[s]) tbl_present[s]++;
    end
    if (r.chunk_last) dropping = 0;
    return st;
  endfunction

  function automatic resp_t predict_table(req_t r);
    resp_t o;
    int s, f;
    o = '0;
    s = find_slot(r.message_id);
    if (r.command == CMD_CHUNK) begin
      if (s < 0) begin
        if (r.chunk_total > NCHUNK || r.message_length > NBYTES) o.status = ST_LARGE;
        else begin
          for (f = 0; f < NSLOT && tbl_valid[f]; f++);
          if (f >= NSLOT) o.status = ST_FULL;
          else begin
            s = f;
            tbl_valid[s] = 1;
            tbl_id[s] = r.message_id;
            tbl_total[s] = r.chunk_total;
            tbl_present[s] = '0;
            tbl_len[s] = r.message_length;
            tbl_seen[s] = '0;
            for (int b = 0; b < NBYTES; b++) tbl_written[s*NBYTES + b] = 0;
          end
        end
      end
      if (s >= 0) begin
        o.status = store_chunk_byte(r, s);
        o.slot_index = 3'(s);
        o.percent_done = slot_percent(s);
        o.complete = tbl_present[s] >= tbl_total[s];
      end
    end else if (s < 0) o.status = ST_NOTFOUND;
    else if (r.command == CMD_READ) begin
      o.slot_index = 3'(s);
      o.percent_done = slot_percent(s);
      o.complete = tbl_present[s] >= tbl_total[s];
      if (r.byte_offset < tbl_len[s]) o.read_data = tbl_bytes[s*NBYTES + r.byte_offset];
      else o.status = ST_RANGE;
    end else if (r.command == CMD_RELEASE) begin
      tbl_valid[s] = 0;
      o.slot_index = 3'(s);
    end else begin
      o.slot_index = 3'(s);
      o.percent_done = slot_percent(s);
      o.complete = tbl_present[s] >= tbl_total[s];
    end
    return o;
  endfunction

  // shadow of slot state as the stimulus sees it, to keep reads on written bytes
  function automatic bit read_is_safe(req_t r);
    int s;
    s = find_slot(r.message_id);
    if (s < 0 || r.byte_offset >= tbl_len[s]) return 1;
    return tbl_written[s*NBYTES + r.byte_offset];
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc_seen) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          req_t r;
          r = pending_beats.pop_front();
          in_valid <= 1;
          in_command <= r.command;
          in_message_id <= r.message_id;
          in_chunk_total <= r.chunk_total;
          in_message_length <= r.message_length;
          in_chunk_index <= r.chunk_index;
          in_byte_offset <= r.byte_offset;
          in_data_byte <= r.data_byte;
          in_chunk_first <= r.chunk_first;
          in_chunk_last <= r.chunk_last;
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // accept at the rising edge: predict there, so reads see the right store state
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_acc_seen <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      req_t r;
      r = '{in_command, in_message_id, in_chunk_total, in_message_length,
            in_chunk_index, in_byte_offset, in_data_byte, in_chunk_first, in_chunk_last};
      expected_resps.push_back(predict_table(r));
    end
    if (rst_n && out_valid && !out_stall) begin
      resp_t got, exp_r;
      got = '{out_status, out_slot_index, out_percent_done, out_complete, out_read_data};
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected beat exp none act %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (got.status != exp_r.status) begin
          $display("%0t: status exp %0d act %0d", $time, exp_r.status, got.status);
          errors++;
        end
        if (got.slot_index != exp_r.slot_index) begin
          $display("%0t: slot exp %0d act %0d", $time, exp_r.slot_index, got.slot_index);
          errors++;
        end
        if (got.percent_done != exp_r.percent_done) begin
          $display("%0t: percent exp %0d act %0d", $time, exp_r.percent_done,
                   got.percent_done);
          errors++;
        end
        if (got.complete != exp_r.complete) begin
          $display("%0t: complete exp %0d act %0d", $time, exp_r.complete, got.complete);
          errors++;
        end
        if (got.read_data != exp_r.read_data) begin
          $display("%0t: read_data exp %0h act %0h", $time, exp_r.read_data,
                   got.read_data);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("chunk_reassembly_table_core_test: errors");
      $finish;
    end
  end

  function automatic req_t mk(logic [1:0] c, logic [15:0] id, int tot, int len,
                              int idx, int off, int d, bit f, bit l);
    req_t r;
    r = '{c, id, 7'(tot), 13'(len), 16'(idx), 12'(off), 8'(d), f, l};
    return r;
  endfunction

  // ids written are tracked so reads only land on written bytes
  int w_id [$];
  int w_off [$];

  task automatic send(req_t r);
    pending_beats.push_back(r);
    if (r.command == CMD_CHUNK) begin
      w_id.push_back(r.message_id);
      w_off.push_back(r.byte_offset);
    end
  endtask

  task automatic wait_drain();
    while (pending_beats.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
  endtask

  // a mostly well formed message: chunks of one to three bytes each, some chunk indices random
  task automatic send_message(logic [15:0] id);
    int tot, per, len;
    tot = $urandom_range(1, 6);
    per = $urandom_range(1, 3);
    len = tot * per;
    if ($urandom_range(9) == 0) len = len - 1;
    for (int c = 0; c < tot; c++) begin
      int ci;
      ci = ($urandom_range(3) == 0) ? $urandom_range(tot - 1) : c;
      for (int b = 0; b < per; b++)
        send(mk(CMD_CHUNK, id, tot, len, ci, ci * per + b, $urandom_range(255),
                b == 0, b == per - 1));
    end
  endtask

  // reads and queries of the byte last sent for the id, else of a random offset
  task automatic send_lookup(logic [15:0] id, logic [1:0] c);
    req_t r;
    int k;
    k = -1;
    for (int i = w_id.size() - 1; i >= 0; i--)
      if (w_id[i] == id) begin
        k = i;
        break;
      end
    r = mk(c, id, 0, 0, 0, (k >= 0) ? w_off[k] : $urandom_range(4095), 0, 0, 0);
    if (c == CMD_READ && !read_is_safe(r)) r.command = CMD_QUERY;
    send(r);
  endtask

  task automatic release_id(logic [15:0] id);
    send(mk(CMD_RELEASE, id, 0, 0, 0, 0, 0, 0, 0));
    for (int i = w_id.size() - 1; i >= 0; i--)
      if (w_id[i] == id) begin
        w_id.delete(i);
        w_off.delete(i);
      end
  endtask

  initial begin
    int pct_set [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{31, 31}};
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: extremes and special cases
    send(mk(CMD_CHUNK, 16'h0000, 2, 4, 0, 0, 8'hff, 1, 0));
    send(mk(CMD_CHUNK, 16'h0000, 2, 4, 0, 1, 8'h00, 0, 1));
    send(mk(CMD_CHUNK, 16'h0000, 2, 4, 0, 0, 8'h55, 1, 1));        // duplicate
    send(mk(CMD_CHUNK, 16'h0000, 2, 4, 65535, 2, 8'haa, 1, 0));    // out of range
    send(mk(CMD_CHUNK, 16'h0000, 2, 4, 1, 4095, 8'h12, 1, 1));     // past length
    send_lookup(16'h0000, CMD_READ);
    send(mk(CMD_READ, 16'h0000, 0, 0, 0, 4095, 0, 0, 0));
    send(mk(CMD_QUERY, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_QUERY, 16'hffff, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_RELEASE, 16'hffff, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 16'hffff, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_CHUNK, 16'hffff, 0, 0, 0, 0, 8'h01, 1, 1));        // zero total
    send(mk(CMD_CHUNK, 16'h1234, 127, 4096, 0, 0, 0, 1, 1));       // too many chunks
    send(mk(CMD_CHUNK, 16'h1234, 64, 8191, 0, 0, 0, 1, 1));        // too long
    send(mk(CMD_CHUNK, 16'h1234, 64, 4096, 63, 4095, 8'h80, 1, 1));
    send(mk(CMD_CHUNK, 16'h1234, 64, 4096, 5, 10, 8'h3c, 0, 1));   // no first byte
    for (int i = 0; i < 7; i++)                                     // fill the table
      send(mk(CMD_CHUNK, 16'(16'h2000 + i), 1, 1, 0, 0, i, 1, 1));
    send_lookup(16'h1234, CMD_READ);
    for (int i = 0; i < 8; i++) send(mk(CMD_RELEASE, 16'(16'h2000 + i), 0, 0, 0, 0, 0, 0, 0));
    release_id(16'h0000);
    release_id(16'hffff);
    release_id(16'h1234);
    wait_drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = pct_set[ph][0];
      out_stall_pct = pct_set[ph][1];
      for (int n = 0; n < 400; ) begin
        logic [15:0] id;
        int sz;
        sz = pending_beats.size();
        id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(11));
        case ($urandom_range(9))
          0, 1, 2, 3: send_message(id);
          4: send_lookup(id, CMD_READ);
          5: send_lookup(id, CMD_QUERY);
          6: release_id(id);
          7: send(mk(CMD_CHUNK, id, $urandom_range(127), $urandom_range(8191),
                     $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom)));
          default: send(mk(CMD_CHUNK, id, $urandom_range(1, 64), $urandom_range(4096),
                           $urandom_range(70), $urandom_range(4095), $urandom,
                           1'($urandom), 1'($urandom)));
        endcase
        n += pending_beats.size() - sz;
        wait_drain();
      end
      for (logic [15:0] i = 0; i < 12; i++) release_id(i);
      wait_drain();
    end
    in_idle_pct = 0;
    out_stall_pct = 0;
    wait_drain();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("chunk_reassembly_table_core_test: clean");
    else $display("chunk_reassembly_table_core_test: errors");
    $finish;
  end

endmodule
